@@ hw/rtl/scfbc_pkg.sv @@
// ----------------------------------------------------------------------------
// scfbc_pkg: shared types and constants of the free block cache
// Field widths, register and operation codes, and the request record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package scfbc_pkg;

	localparam int SLOTS_PER_TABLE_DEF = 32;
	localparam int TABLE_COUNT = 9;
	localparam int CLASS_COUNT = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam int SIZE_W = 40;
	localparam int ADDR_W = 48;
	localparam int TOTAL_W = 45;
	localparam int SLOT_CNT_W = 5;
	localparam int TBL_W = 4;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [KIND_W-1:0] KIND_HOST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHARED = 2'd2;

	localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = 40'd4096;
	localparam logic [SIZE_W-1:0] HUGE_LIMIT_RST = 40'd2097152;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_HOST_LARGE_RST = 5'd2;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_DEV_LARGE_RST = 5'd8;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_HOST_SMALL_RST = 5'd8;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_DEV_SMALL_RST = 5'd16;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_HUGE_RST = 5'd0;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CLS_LARGE = 2'd0,
		CLS_HUGE = 2'd1,
		CLS_SMALL = 2'd2
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMALL_LIMIT = 3'd0,
		REG_HUGE_LIMIT = 3'd1,
		REG_SLOTS_HOST_LARGE = 3'd2,
		REG_SLOTS_DEV_LARGE = 3'd3,
		REG_SLOTS_HOST_SMALL = 3'd4,
		REG_SLOTS_DEV_SMALL = 3'd5,
		REG_SLOTS_HUGE = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DISPATCH,
		BK_LK_SCAN,
		BK_LK_CMP,
		BK_EV_SUB,
		BK_EV_ADD
	} bk_state_t;

	typedef struct packed {
		op_t op;
		logic kind_ok;
		logic [TBL_W-1:0] tbl;
		logic [SLOT_CNT_W-1:0] nslots;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} item_t;

endpackage

@@ hw/rtl/scfbc_ram.sv @@
// ----------------------------------------------------------------------------
// scfbc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module scfbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/scfbc_front.sv @@
// ----------------------------------------------------------------------------
// scfbc_front: configuration registers and request classification
// Picks the table from memory kind and size class and the slots in use,
// and pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module scfbc_front #(
	parameter int SLOTS_PER_TABLE = scfbc_pkg::SLOTS_PER_TABLE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [scfbc_pkg::KIND_W-1:0] mem_kind,
	input logic [scfbc_pkg::SIZE_W-1:0] size_bytes,
	input logic [scfbc_pkg::ADDR_W-1:0] block_address,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [scfbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [scfbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic q_full,
	output logic push,
	output scfbc_pkg::item_t push_item
);

	logic [scfbc_pkg::SIZE_W-1:0] small_limit_q;
	logic [scfbc_pkg::SIZE_W-1:0] huge_limit_q;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_host_large_q;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_dev_large_q;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_host_small_q;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_dev_small_q;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_huge_q;

	scfbc_pkg::cls_t cls;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_raw;
	logic [scfbc_pkg::SLOT_CNT_W-1:0] slots_used;

	assign cfg_ready = 1'b1;
	assign busy = q_full;
	assign push = start && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_limit_q <= scfbc_pkg::SMALL_LIMIT_RST;
			huge_limit_q <= scfbc_pkg::HUGE_LIMIT_RST;
			slots_host_large_q <= scfbc_pkg::SLOTS_HOST_LARGE_RST;
			slots_dev_large_q <= scfbc_pkg::SLOTS_DEV_LARGE_RST;
			slots_host_small_q <= scfbc_pkg::SLOTS_HOST_SMALL_RST;
			slots_dev_small_q <= scfbc_pkg::SLOTS_DEV_SMALL_RST;
			slots_huge_q <= scfbc_pkg::SLOTS_HUGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (scfbc_pkg::cfg_reg_t'(cfg_index))
				scfbc_pkg::REG_SMALL_LIMIT: small_limit_q <= cfg_data[scfbc_pkg::SIZE_W-1:0];
				scfbc_pkg::REG_HUGE_LIMIT: huge_limit_q <= cfg_data[scfbc_pkg::SIZE_W-1:0];
				scfbc_pkg::REG_SLOTS_HOST_LARGE: begin
					slots_host_large_q <= cfg_data[scfbc_pkg::SLOT_CNT_W-1:0];
				end
				scfbc_pkg::REG_SLOTS_DEV_LARGE: begin
					slots_dev_large_q <= cfg_data[scfbc_pkg::SLOT_CNT_W-1:0];
				end
				scfbc_pkg::REG_SLOTS_HOST_SMALL: begin
					slots_host_small_q <= cfg_data[scfbc_pkg::SLOT_CNT_W-1:0];
				end
				scfbc_pkg::REG_SLOTS_DEV_SMALL: begin
					slots_dev_small_q <= cfg_data[scfbc_pkg::SLOT_CNT_W-1:0];
				end
				scfbc_pkg::REG_SLOTS_HUGE: slots_huge_q <= cfg_data[scfbc_pkg::SLOT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_bytes < small_limit_q) begin
			cls = scfbc_pkg::CLS_SMALL;
		end else if (size_bytes >= huge_limit_q) begin
			cls = scfbc_pkg::CLS_HUGE;
		end else begin
			cls = scfbc_pkg::CLS_LARGE;
		end
	end

	// Host large and small tables have own counts; the rest share one per class.
	always_comb begin
		case (cls)
			scfbc_pkg::CLS_HUGE: slots_raw = slots_huge_q;
			scfbc_pkg::CLS_LARGE: begin
				slots_raw = (mem_kind == scfbc_pkg::KIND_HOST) ? slots_host_large_q
					: slots_dev_large_q;
			end
			scfbc_pkg::CLS_SMALL: begin
				slots_raw = (mem_kind == scfbc_pkg::KIND_HOST) ? slots_host_small_q
					: slots_dev_small_q;
			end
			default: slots_raw = '0;
		endcase
		if (int'(slots_raw) > SLOTS_PER_TABLE) begin
			slots_used = scfbc_pkg::SLOT_CNT_W'(SLOTS_PER_TABLE);
		end else begin
			slots_used = slots_raw;
		end
	end

	always_comb begin
		push_item.op = scfbc_pkg::op_t'(opcode);
		push_item.kind_ok = (mem_kind <= scfbc_pkg::KIND_SHARED);
		push_item.tbl = scfbc_pkg::TBL_W'(mem_kind) * scfbc_pkg::TBL_W'(scfbc_pkg::CLASS_COUNT)
			+ scfbc_pkg::TBL_W'(cls);
		push_item.nslots = slots_used;
		push_item.size = size_bytes;
		push_item.addr = block_address;
	end

endmodule

@@ hw/rtl/scfbc_queue.sv @@
// ----------------------------------------------------------------------------
// scfbc_queue: short request queue between front end and back end
// A small circular buffer; the head is read directly.
// ----------------------------------------------------------------------------
module scfbc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input scfbc_pkg::item_t push_item,
	output logic full,
	input logic pop,
	output logic empty,
	output scfbc_pkg::item_t head
);

	localparam int PTR_W = (scfbc_pkg::QUEUE_DEPTH > 1) ? $clog2(scfbc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(scfbc_pkg::QUEUE_DEPTH + 1);

	scfbc_pkg::item_t buf_q [scfbc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(scfbc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = buf_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(scfbc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/scfbc_back.sv @@
// ----------------------------------------------------------------------------
// scfbc_back: lookup and insert engine
// Holds valid bits, victim pointers and byte totals of the nine tables and
// the entry RAM; scans the slots one at a time and writes results back.
// ----------------------------------------------------------------------------
module scfbc_back #(
	parameter int SLOTS_PER_TABLE = scfbc_pkg::SLOTS_PER_TABLE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input scfbc_pkg::item_t q_head,
	output logic q_pop,
	output logic done,
	output logic hit,
	output logic release_res,
	output logic [scfbc_pkg::ADDR_W-1:0] out_address,
	output logic [scfbc_pkg::TOTAL_W-1:0] table_bytes
);

	localparam int SLOT_W = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
	localparam int CMP_W = ((SLOT_W > scfbc_pkg::SLOT_CNT_W) ? SLOT_W
		: scfbc_pkg::SLOT_CNT_W) + 1;
	localparam int RAM_DEPTH = scfbc_pkg::TABLE_COUNT * SLOTS_PER_TABLE;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int RAM_W = scfbc_pkg::ADDR_W + scfbc_pkg::SIZE_W;

	scfbc_pkg::bk_state_t state_q, state_d;
	scfbc_pkg::item_t cur_q;
	logic [SLOT_W:0] scan_q;
	logic [SLOT_W-1:0] slot_q;
	logic [scfbc_pkg::ADDR_W-1:0] oaddr_q;
	logic [SLOTS_PER_TABLE-1:0] valid_q [scfbc_pkg::TABLE_COUNT];
	logic [SLOT_W-1:0] vp_q [scfbc_pkg::TABLE_COUNT];
	logic [scfbc_pkg::TOTAL_W-1:0] tot_q [scfbc_pkg::TABLE_COUNT];

	logic done_q, hit_q, rel_q;
	logic [scfbc_pkg::ADDR_W-1:0] out_addr_q;
	logic [scfbc_pkg::TOTAL_W-1:0] bytes_q;

	logic [CMP_W-1:0] n_ext;
	logic [SLOTS_PER_TABLE-1:0] row;
	logic [scfbc_pkg::TOTAL_W-1:0] tot_cur;
	logic free_found;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] victim, victim_next;
	logic [SLOT_W-1:0] scan_slot;
	logic scan_done, scan_valid;
	logic [scfbc_pkg::ADDR_W-1:0] rd_addr;
	logic [scfbc_pkg::SIZE_W-1:0] rd_size;
	logic size_match;
	logic is_insert, ins_empty_tbl, ins_full;

	logic ram_we, ram_re;
	logic [SLOT_W-1:0] ram_wslot, ram_rslot;
	logic [RAM_AW-1:0] ram_base, ram_waddr, ram_raddr;
	logic [RAM_W-1:0] ram_rdata;

	logic tot_we, tot_sub;
	logic [scfbc_pkg::TOTAL_W-1:0] tot_opnd, tot_new;
	logic valid_set, valid_clr, vp_we, scan_clr, scan_inc, slot_ld, oaddr_ld;
	logic [SLOT_W-1:0] valid_slot;
	logic res_emit, res_hit, res_rel;
	logic [scfbc_pkg::ADDR_W-1:0] res_addr;
	logic [scfbc_pkg::TOTAL_W-1:0] res_bytes;

	always_comb begin
		n_ext = CMP_W'(cur_q.nslots);
		row = valid_q[cur_q.tbl];
		tot_cur = tot_q[cur_q.tbl];
		is_insert = (cur_q.op == scfbc_pkg::OP_INSERT);
		ins_empty_tbl = is_insert && (cur_q.nslots == '0);

		// Lowest free slot within the slots in use.
		free_found = 1'b0;
		free_slot = '0;
		for (int i = SLOTS_PER_TABLE - 1; i >= 0; i--) begin
			if (!row[i] && (CMP_W'(i) < n_ext)) begin
				free_found = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
		ins_full = is_insert && !ins_empty_tbl && !free_found;

		// A pointer left beyond a lowered slot count restarts at slot zero.
		victim = (CMP_W'(vp_q[cur_q.tbl]) >= n_ext) ? '0 : vp_q[cur_q.tbl];
		victim_next = ((CMP_W'(victim) + CMP_W'(1)) == n_ext) ? '0 : victim + SLOT_W'(1);

		scan_slot = scan_q[SLOT_W-1:0];
		scan_done = (CMP_W'(scan_q) >= n_ext);
		scan_valid = row[scan_slot];

		rd_addr = ram_rdata[RAM_W-1:scfbc_pkg::SIZE_W];
		rd_size = ram_rdata[scfbc_pkg::SIZE_W-1:0];
		size_match = (rd_size == cur_q.size);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			scfbc_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = scfbc_pkg::BK_DISPATCH;
				end
			end
			scfbc_pkg::BK_DISPATCH: begin
				if (!cur_q.kind_ok) begin
					state_d = scfbc_pkg::BK_IDLE;
				end else if (!is_insert) begin
					state_d = scfbc_pkg::BK_LK_SCAN;
				end else if (ins_full) begin
					state_d = scfbc_pkg::BK_EV_SUB;
				end else begin
					state_d = scfbc_pkg::BK_IDLE;
				end
			end
			scfbc_pkg::BK_LK_SCAN: begin
				if (scan_done) begin
					state_d = scfbc_pkg::BK_IDLE;
				end else if (scan_valid) begin
					state_d = scfbc_pkg::BK_LK_CMP;
				end
			end
			scfbc_pkg::BK_LK_CMP: begin
				state_d = size_match ? scfbc_pkg::BK_IDLE : scfbc_pkg::BK_LK_SCAN;
			end
			scfbc_pkg::BK_EV_SUB: state_d = scfbc_pkg::BK_EV_ADD;
			scfbc_pkg::BK_EV_ADD: state_d = scfbc_pkg::BK_IDLE;
			default: state_d = scfbc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_wslot = free_slot;
		ram_rslot = scan_slot;
		tot_we = 1'b0;
		tot_sub = 1'b0;
		tot_opnd = scfbc_pkg::TOTAL_W'(cur_q.size);
		valid_set = 1'b0;
		valid_clr = 1'b0;
		valid_slot = free_slot;
		vp_we = 1'b0;
		scan_clr = 1'b0;
		scan_inc = 1'b0;
		slot_ld = 1'b0;
		oaddr_ld = 1'b0;
		res_emit = 1'b0;
		res_hit = 1'b0;
		res_rel = 1'b0;
		res_addr = '0;
		res_bytes = tot_cur;
		case (state_q)
			scfbc_pkg::BK_IDLE: q_pop = !q_empty;
			scfbc_pkg::BK_DISPATCH: begin
				if (!cur_q.kind_ok) begin
					res_emit = 1'b1;
					res_bytes = '0;
				end else if (!is_insert) begin
					scan_clr = 1'b1;
				end else if (ins_empty_tbl) begin
					res_emit = 1'b1;
					res_rel = 1'b1;
					res_addr = cur_q.addr;
				end else if (free_found) begin
					ram_we = 1'b1;
					valid_set = 1'b1;
					tot_we = 1'b1;
					res_emit = 1'b1;
					res_bytes = tot_new;
				end else begin
					ram_re = 1'b1;
					ram_rslot = victim;
					vp_we = 1'b1;
					slot_ld = 1'b1;
				end
			end
			scfbc_pkg::BK_LK_SCAN: begin
				if (scan_done) begin
					res_emit = 1'b1;
				end else if (scan_valid) begin
					ram_re = 1'b1;
				end else begin
					scan_inc = 1'b1;
				end
			end
			scfbc_pkg::BK_LK_CMP: begin
				if (size_match) begin
					valid_clr = 1'b1;
					valid_slot = scan_slot;
					tot_we = 1'b1;
					tot_sub = 1'b1;
					res_emit = 1'b1;
					res_hit = 1'b1;
					res_addr = rd_addr;
					res_bytes = tot_new;
				end else begin
					scan_inc = 1'b1;
				end
			end
			scfbc_pkg::BK_EV_SUB: begin
				// The victim leaves the total here; the new size is added next step.
				tot_we = 1'b1;
				tot_sub = 1'b1;
				tot_opnd = scfbc_pkg::TOTAL_W'(rd_size);
				ram_we = 1'b1;
				ram_wslot = slot_q;
				oaddr_ld = 1'b1;
			end
			scfbc_pkg::BK_EV_ADD: begin
				tot_we = 1'b1;
				res_emit = 1'b1;
				res_rel = 1'b1;
				res_addr = oaddr_q;
				res_bytes = tot_new;
			end
			default: ;
		endcase
	end

	assign tot_new = tot_sub ? tot_cur - tot_opnd : tot_cur + tot_opnd;

	assign ram_base = RAM_AW'(int'(cur_q.tbl) * SLOTS_PER_TABLE);
	assign ram_waddr = ram_base + RAM_AW'(ram_wslot);
	assign ram_raddr = ram_base + RAM_AW'(ram_rslot);

	scfbc_ram #(
		.WIDTH(RAM_W),
		.DEPTH(RAM_DEPTH)
	) u_entry_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata({cur_q.addr, cur_q.size}),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scfbc_pkg::BK_IDLE;
			done_q <= 1'b0;
			for (int t = 0; t < scfbc_pkg::TABLE_COUNT; t++) begin
				valid_q[t] <= '0;
				vp_q[t] <= '0;
				tot_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q <= res_emit;
			if (valid_set) begin
				valid_q[cur_q.tbl][valid_slot] <= 1'b1;
			end else if (valid_clr) begin
				valid_q[cur_q.tbl][valid_slot] <= 1'b0;
			end
			if (vp_we) begin
				vp_q[cur_q.tbl] <= victim_next;
			end
			if (tot_we) begin
				tot_q[cur_q.tbl] <= tot_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (scan_clr) begin
			scan_q <= '0;
		end else if (scan_inc) begin
			scan_q <= scan_q + (SLOT_W + 1)'(1);
		end
		if (slot_ld) begin
			slot_q <= victim;
		end
		if (oaddr_ld) begin
			oaddr_q <= rd_addr;
		end
		if (res_emit) begin
			hit_q <= res_hit;
			rel_q <= res_rel;
			out_addr_q <= res_addr;
			bytes_q <= res_bytes;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign release_res = rel_q;
	assign out_address = out_addr_q;
	assign table_bytes = bytes_q;

endmodule

@@ hw/rtl/size_class_free_block_cache_top.sv @@
// ----------------------------------------------------------------------------
// size_class_free_block_cache_top: free block cache with nine tables
// Caches freed blocks per memory kind and size class, with exact-size
// lookup and round-robin replacement on insert.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  request   | start / busy            | opcode, mem_kind, size_bytes,
//            |                         | block_address
//  result    | done (one-cycle strobe) | hit, release_res, out_address,
//            |                         | table_bytes
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A taken request waits in the queue until the idle engine fetches it. A bad
// memory kind, an insert into a free slot or into a zero-slot table gives its
// result from the dispatch state; an eviction goes on through a subtract and
// an add state. A lookup scans the slots in use one at a time and spends an extra
// compare step on the entry RAM read for each valid slot.
// Reset clears all valid bits, victim pointers and totals at once.
// The two-deep queue raises busy only when full; results are never held off.
module size_class_free_block_cache_top #(
	parameter int SLOTS_PER_TABLE = scfbc_pkg::SLOTS_PER_TABLE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [scfbc_pkg::KIND_W-1:0] mem_kind,
	input logic [scfbc_pkg::SIZE_W-1:0] size_bytes,
	input logic [scfbc_pkg::ADDR_W-1:0] block_address,
	output logic done,
	output logic hit,
	output logic release_res,
	output logic [scfbc_pkg::ADDR_W-1:0] out_address,
	output logic [scfbc_pkg::TOTAL_W-1:0] table_bytes,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [scfbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [scfbc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic q_full, q_empty, push, pop;
	scfbc_pkg::item_t push_item, head;

	scfbc_front #(
		.SLOTS_PER_TABLE(SLOTS_PER_TABLE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.mem_kind(mem_kind),
		.size_bytes(size_bytes),
		.block_address(block_address),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	scfbc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.empty(q_empty),
		.head(head)
	);

	scfbc_back #(
		.SLOTS_PER_TABLE(SLOTS_PER_TABLE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(head),
		.q_pop(pop),
		.done(done),
		.hit(hit),
		.release_res(release_res),
		.out_address(out_address),
		.table_bytes(table_bytes)
	);

	// Results never come back to back; the engine returns to idle to fetch the next request.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on two consecutive cycles");

	// No result both hits and releases: a lookup never releases and an insert never hits.
	a_hit_rel: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && release_res))
		else $error("hit and release on the same result");

	// The queue can only fill on a request taken in the previous cycle.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(push))
		else $error("busy rose without a request");

	// The engine only fetches what the queue holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("request fetched from an empty queue");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the size-class free block cache
// Drives lookup and insert requests in bursts across several register
// settings, keeps its own shadow of all nine tables, and compares every
// result strobe field by field against the outcome it predicted.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scfbc_pkg::*;

	localparam int SLOTS = SLOTS_PER_TABLE_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int SHOWN_ERRORS = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
	localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
	localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		op_t op;
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} cache_req_t;

	typedef struct packed {
		logic hit;
		logic rel;
		logic [ADDR_W-1:0] addr;
		logic [TOTAL_W-1:0] total;
	} cache_outcome_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] size;
	} freed_size_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = 1'b0;
	logic [KIND_W-1:0] mem_kind = '0;
	logic [SIZE_W-1:0] size_bytes = '0;
	logic [ADDR_W-1:0] block_address = '0;
	logic done;
	logic hit;
	logic release_res;
	logic [ADDR_W-1:0] out_address;
	logic [TOTAL_W-1:0] table_bytes;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the configuration and of the nine tables.
	logic [SIZE_W-1:0] lim_small, lim_huge;
	logic [SLOT_CNT_W-1:0] cnt_host_large, cnt_dev_large, cnt_host_small;
	logic [SLOT_CNT_W-1:0] cnt_dev_small, cnt_huge;
	logic slot_valid [TABLE_COUNT][SLOTS];
	logic [ADDR_W-1:0] slot_addr [TABLE_COUNT][SLOTS];
	logic [SIZE_W-1:0] slot_size [TABLE_COUNT][SLOTS];
	logic [SLOT_CNT_W-1:0] rr_ptr [TABLE_COUNT];
	logic [TOTAL_W-1:0] tbl_total [TABLE_COUNT];

	cache_outcome_t pending_outcomes[$];
	freed_size_t freed_sizes[$];
	reg_write_t reg_writes[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	size_class_free_block_cache_top #(.SLOTS_PER_TABLE(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.mem_kind(mem_kind),
		.size_bytes(size_bytes),
		.block_address(block_address),
		.done(done),
		.hit(hit),
		.release_res(release_res),
		.out_address(out_address),
		.table_bytes(table_bytes),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	task automatic clear_shadow();
		lim_small = SMALL_LIMIT_RST;
		lim_huge = HUGE_LIMIT_RST;
		cnt_host_large = SLOTS_HOST_LARGE_RST;
		cnt_dev_large = SLOTS_DEV_LARGE_RST;
		cnt_host_small = SLOTS_HOST_SMALL_RST;
		cnt_dev_small = SLOTS_DEV_SMALL_RST;
		cnt_huge = SLOTS_HUGE_RST;
		for (int t = 0; t < TABLE_COUNT; t++) begin
			rr_ptr[t] = '0;
			tbl_total[t] = '0;
			for (int e = 0; e < SLOTS; e++) begin
				slot_valid[t][e] = 1'b0;
				slot_addr[t][e] = '0;
				slot_size[t][e] = '0;
			end
		end
	endtask

	task automatic shadow_reg_write(input reg_write_t w);
		case (w.idx)
			REG_SMALL_LIMIT: lim_small = w.data;
			REG_HUGE_LIMIT: lim_huge = w.data;
			REG_SLOTS_HOST_LARGE: cnt_host_large = w.data[SLOT_CNT_W-1:0];
			REG_SLOTS_DEV_LARGE: cnt_dev_large = w.data[SLOT_CNT_W-1:0];
			REG_SLOTS_HOST_SMALL: cnt_host_small = w.data[SLOT_CNT_W-1:0];
			REG_SLOTS_DEV_SMALL: cnt_dev_small = w.data[SLOT_CNT_W-1:0];
			REG_SLOTS_HUGE: cnt_huge = w.data[SLOT_CNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic int unsigned slots_in_use(input int unsigned tbl);
		int unsigned n;
		if (cls_t'(tbl % CLASS_COUNT) == CLS_HUGE)
			n = cnt_huge;
		else if (tbl == 0)
			n = cnt_host_large;
		else if (tbl == 2)
			n = cnt_host_small;
		else if (cls_t'(tbl % CLASS_COUNT) == CLS_LARGE)
			n = cnt_dev_large;
		else
			n = cnt_dev_small;
		return (n > SLOTS) ? SLOTS : n;
	endfunction

	// Applies one request to the shadow tables and returns what the block
	// should report for it.
	task automatic cache_op_outcome(input cache_req_t r, output cache_outcome_t o);
		cls_t cls;
		int unsigned tbl, n, v;
		logic found;
		o = '0;
		found = 1'b0;
		if (r.kind <= KIND_SHARED) begin
			if (r.size < lim_small)
				cls = CLS_SMALL;
			else if (r.size >= lim_huge)
				cls = CLS_HUGE;
			else
				cls = CLS_LARGE;
			tbl = r.kind * CLASS_COUNT + int'(cls);
			n = slots_in_use(tbl);
			if (r.op == OP_LOOKUP) begin
				for (int unsigned e = 0; e < n; e++) begin
					if (!found && slot_valid[tbl][e] && slot_size[tbl][e] == r.size) begin
						found = 1'b1;
						slot_valid[tbl][e] = 1'b0;
						tbl_total[tbl] = tbl_total[tbl] - r.size;
						o.hit = 1'b1;
						o.addr = slot_addr[tbl][e];
					end
				end
			end else if (n == 0) begin
				o.rel = 1'b1;
				o.addr = r.addr;
			end else begin
				v = n;
				for (int unsigned e = 0; e < n; e++)
					if (v == n && !slot_valid[tbl][e])
						v = e;
				if (v == n) begin
					// A pointer left beyond a lowered slot count restarts at zero.
					v = rr_ptr[tbl];
					if (v >= n)
						v = 0;
					rr_ptr[tbl] = SLOT_CNT_W'((v + 1) % n);
				end
				if (slot_valid[tbl][v]) begin
					o.rel = 1'b1;
					o.addr = slot_addr[tbl][v];
					tbl_total[tbl] = tbl_total[tbl] - slot_size[tbl][v];
				end
				slot_valid[tbl][v] = 1'b1;
				slot_addr[tbl][v] = r.addr;
				slot_size[tbl][v] = r.size;
				tbl_total[tbl] = tbl_total[tbl] + r.size;
			end
			o.total = tbl_total[tbl];
		end
	endtask

	// Holds start high until the request is taken, then records its outcome.
	task automatic send_item(input cache_req_t r);
		cache_outcome_t o;
		start <= 1'b1;
		opcode <= r.op;
		mem_kind <= r.kind;
		size_bytes <= r.size;
		block_address <= r.addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cache_op_outcome(r, o);
		pending_outcomes.push_back(o);
	endtask

	task automatic send_req(input op_t op, input logic [KIND_W-1:0] kind,
			input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] addr);
		cache_req_t r;
		r.op = op;
		r.kind = kind;
		r.size = size;
		r.addr = addr;
		send_item(r);
	endtask

	task automatic idle_until_drained();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		reg_write_t w;
		w.idx = idx;
		w.data = data;
		reg_writes.push_back(w);
	endtask

	// Slot counts carry random upper bits so that the width masking is seen.
	task automatic queue_slot_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [SLOT_CNT_W-1:0] n);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		queue_reg_write(idx, {noise[CFG_DATA_W-1:SLOT_CNT_W], n});
	endtask

	task automatic flush_reg_writes();
		reg_write_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			shadow_reg_write(w);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SIZE_W-1:0] random_size();
		logic [63:0] w;
		logic [SIZE_W-1:0] anchor;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0, 1: random_size = w[SIZE_W-1:0];
			2: random_size = '0;
			3: random_size = SIZE_MAX;
			4: random_size = lim_small - 1'b1;
			5: random_size = lim_small;
			6: random_size = lim_huge - 1'b1;
			7: random_size = lim_huge;
			default: begin
				// A few nearby sizes per class so that exact matches recur.
				case ($urandom_range(0, 2))
					0: anchor = '0;
					1: anchor = lim_small;
					default: anchor = lim_huge;
				endcase
				random_size = anchor + SIZE_W'($urandom_range(0, 15) * 8);
			end
		endcase
	endfunction

	function automatic cache_req_t random_request();
		cache_req_t r;
		freed_size_t f;
		logic [63:0] w;
		w = {$urandom, $urandom};
		r.op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_LOOKUP;
		r.kind = ($urandom_range(0, 15) == 0) ? KIND_BAD : KIND_W'($urandom_range(0, 2));
		r.size = random_size();
		case ($urandom_range(0, 19))
			0: r.addr = '0;
			1: r.addr = ADDR_MAX;
			default: r.addr = w[ADDR_W-1:0];
		endcase
		if (freed_sizes.size() != 0 &&
				$urandom_range(0, 99) < ((r.op == OP_LOOKUP) ? 70 : 10)) begin
			f = freed_sizes[$urandom_range(0, freed_sizes.size() - 1)];
			r.kind = f.kind;
			r.size = f.size;
		end
		if (r.op == OP_INSERT) begin
			f.kind = r.kind;
			f.size = r.size;
			freed_sizes.push_back(f);
			if (freed_sizes.size() > 48)
				void'(freed_sizes.pop_front());
		end
		return r;
	endfunction

	// Random requests in bursts; now and then a long burst with no gaps.
	task automatic run_random(input int count);
		int burst_left;
		burst_left = $urandom_range(1, 20);
		repeat (count) begin
			send_item(random_request());
			burst_left--;
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
			end
		end
		idle_until_drained();
	endtask

	function automatic logic [SIZE_W-1:0] random_limit();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: random_limit = '0;
			1: random_limit = SIZE_MAX;
			2: random_limit = SIZE_W'($urandom_range(1, 65536));
			3: random_limit = w[SIZE_W-1:0];
			default: random_limit = SIZE_W'($urandom_range(4096, 4194304));
		endcase
	endfunction

	function automatic logic [SLOT_CNT_W-1:0] random_slots();
		case ($urandom_range(0, 5))
			0: random_slots = '0;
			1: random_slots = '1;
			default: random_slots = SLOT_CNT_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Reset settings: class boundaries, the bad kind, round-robin eviction,
	// the pass-back of a zero-slot table and size and address extremes.
	task automatic test_default_tables();
		send_req(OP_LOOKUP, KIND_BAD, 40'd100, '0);
		send_req(OP_INSERT, KIND_BAD, SIZE_MAX, ADDR_MAX);
		send_req(OP_INSERT, KIND_HOST, 40'd100, 48'h0000_1000_0001);
		send_req(OP_INSERT, KIND_HOST, 40'd100, 48'h0000_1000_0002);
		send_req(OP_LOOKUP, KIND_HOST, 40'd100, '0);
		send_req(OP_LOOKUP, KIND_HOST, 40'd101, '0);
		send_req(OP_INSERT, KIND_HOST, SMALL_LIMIT_RST - 1'b1, 48'h0000_2000_0001);
		send_req(OP_INSERT, KIND_HOST, SMALL_LIMIT_RST, 48'h0000_3000_0001);
		send_req(OP_INSERT, KIND_HOST, HUGE_LIMIT_RST - 1'b1, 48'h0000_3000_0002);
		send_req(OP_INSERT, KIND_HOST, 40'd5000, 48'h0000_3000_0003);
		send_req(OP_INSERT, KIND_HOST, 40'd6000, 48'h0000_3000_0004);
		send_req(OP_LOOKUP, KIND_HOST, HUGE_LIMIT_RST, '0);
		send_req(OP_INSERT, KIND_HOST, HUGE_LIMIT_RST, 48'h0000_4000_0001);
		send_req(OP_INSERT, KIND_ACCEL, SIZE_MAX, ADDR_MAX);
		send_req(OP_INSERT, KIND_SHARED, '0, '0);
		send_req(OP_LOOKUP, KIND_SHARED, '0, ADDR_MAX);
		send_req(OP_LOOKUP, KIND_ACCEL, '0, '0);
		send_req(OP_INSERT, KIND_ACCEL, SMALL_LIMIT_RST, 48'hAAAA_AAAA_AAAA);
		send_req(OP_LOOKUP, KIND_ACCEL, SMALL_LIMIT_RST, '0);
		send_req(OP_LOOKUP, KIND_HOST, 40'd6000, '0);
		send_req(OP_INSERT, KIND_SHARED, 40'h55_5555_5555, 48'h5555_5555_5555);
		idle_until_drained();
	endtask

	// Both threshold extremes, each slot count at its top, all but huge and dev large at zero.
	task automatic test_limit_extremes();
		queue_reg_write(REG_SMALL_LIMIT, '0);
		queue_reg_write(REG_HUGE_LIMIT, SIZE_MAX);
		queue_slot_write(REG_SLOTS_HOST_LARGE, 5'd31);
		queue_slot_write(REG_SLOTS_DEV_LARGE, 5'd1);
		queue_slot_write(REG_SLOTS_HOST_SMALL, 5'd0);
		queue_slot_write(REG_SLOTS_DEV_SMALL, 5'd31);
		queue_slot_write(REG_SLOTS_HUGE, 5'd31);
		queue_reg_write(REG_UNUSED, SIZE_MAX);
		flush_reg_writes();
		run_random(250);
		queue_reg_write(REG_SMALL_LIMIT, SIZE_MAX);
		queue_reg_write(REG_HUGE_LIMIT, '0);
		queue_slot_write(REG_SLOTS_HOST_LARGE, 5'd0);
		queue_slot_write(REG_SLOTS_DEV_LARGE, 5'd31);
		queue_slot_write(REG_SLOTS_HOST_SMALL, 5'd31);
		queue_slot_write(REG_SLOTS_DEV_SMALL, 5'd0);
		queue_slot_write(REG_SLOTS_HUGE, 5'd2);
		flush_reg_writes();
		run_random(250);
	endtask

	// Fill an accelerator large table, lower its slot count below the victim
	// pointer, then raise it again to find the entries that were hidden.
	task automatic test_stale_victim();
		queue_reg_write(REG_SMALL_LIMIT, 40'd16);
		queue_reg_write(REG_HUGE_LIMIT, 40'd1048576);
		queue_slot_write(REG_SLOTS_DEV_LARGE, 5'd4);
		flush_reg_writes();
		for (int i = 0; i < 6; i++)
			send_req(OP_INSERT, KIND_ACCEL, SIZE_W'(1000 + i), ADDR_W'(48'h0000_7000_0000 + i));
		idle_until_drained();
		queue_slot_write(REG_SLOTS_DEV_LARGE, 5'd2);
		flush_reg_writes();
		send_req(OP_INSERT, KIND_ACCEL, 40'd1006, 48'h0000_7000_0006);
		send_req(OP_LOOKUP, KIND_ACCEL, 40'd1002, '0);
		send_req(OP_LOOKUP, KIND_ACCEL, 40'd1005, '0);
		send_req(OP_INSERT, KIND_ACCEL, 40'd1007, 48'h0000_7000_0007);
		idle_until_drained();
		queue_slot_write(REG_SLOTS_DEV_LARGE, 5'd4);
		flush_reg_writes();
		send_req(OP_LOOKUP, KIND_ACCEL, 40'd1002, '0);
		send_req(OP_LOOKUP, KIND_ACCEL, 40'd1003, '0);
		send_req(OP_INSERT, KIND_ACCEL, 40'd1008, 48'h0000_7000_0008);
		send_req(OP_INSERT, KIND_ACCEL, 40'd1009, 48'h0000_7000_0009);
		idle_until_drained();
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 4; round++) begin
			queue_reg_write(REG_SMALL_LIMIT, random_limit());
			queue_reg_write(REG_HUGE_LIMIT, random_limit());
			queue_slot_write(REG_SLOTS_HOST_LARGE, random_slots());
			queue_slot_write(REG_SLOTS_DEV_LARGE, random_slots());
			queue_slot_write(REG_SLOTS_HOST_SMALL, random_slots());
			queue_slot_write(REG_SLOTS_DEV_SMALL, random_slots());
			queue_slot_write(REG_SLOTS_HUGE, random_slots());
			flush_reg_writes();
			run_random(220);
		end
	endtask

	always @(posedge clk) begin : check_results
		cache_outcome_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				want = pending_outcomes.pop_front();
				if (hit !== want.hit || release_res !== want.rel ||
						out_address !== want.addr || table_bytes !== want.total) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("result %0d: hit %b/%b rel %b/%b addr %h/%h total %h/%h",
							results_seen, hit, want.hit, release_res, want.rel,
							out_address, want.addr, table_bytes, want.total);
				end
			end
		end
	end

	// Ends the run when no request, result or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		clear_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_tables();
		test_limit_extremes();
		test_stale_victim();
		test_random_settings();
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
